// File: rtl/bpal_pkg.sv
// ----------------------------------------------------------------------------
// bpal_pkg
// shared constants, operation codes and point types for the bezier path
// arc-length evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bpal_pkg;

  localparam int BPAL_MAX_SEGMENTS        = 4;
  localparam int BPAL_ENTRIES_PER_SEGMENT = 50;
  localparam int BPAL_SAMPLES_PER_ENTRY   = 10;

  localparam int NUM_AXES    = 3;
  localparam int PTS_PER_SEG = 4;
  localparam int CP_PER_SEG  = PTS_PER_SEG * NUM_AXES;

  // operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_AT_TIME = 2'd2;
  localparam logic [1:0] OP_AT_DIST = 2'd3;

  // status codes
  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_BAD_SEG = 1'b1;

  localparam logic [16:0] T_ONE    = 17'h10000;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef logic [32:0] weight_t;

endpackage

`default_nettype wire

// File: rtl/bpal_if.sv
// ----------------------------------------------------------------------------
// bpal_if
// valid/ready channels of the evaluator: command words, result words and
// the segment count register write
// ----------------------------------------------------------------------------
`default_nettype none

interface bpal_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [1:0]         segment;
  logic [1:0]         point_index;
  logic [1:0]         axis;
  logic signed [15:0] coord_value;
  logic [16:0]        time_value;
  logic [23:0]        distance_value;

  modport source (output valid, operation, segment, point_index, axis, coord_value,
                  time_value, distance_value, input ready);
  modport sink   (input valid, operation, segment, point_index, axis, coord_value,
                  time_value, distance_value, output ready);
endinterface

interface bpal_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;

  modport source (output valid, status, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, status, pos_x, pos_y, pos_z, output ready);
endinterface

interface bpal_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/bpal_point.sv
// ----------------------------------------------------------------------------
// bpal_point
// control point store and cubic bezier point evaluator: bernstein weights
// then twelve multiply-accumulates through one shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module bpal_point
  import bpal_pkg::*;
#(
  parameter int MAX_SEGMENTS = BPAL_MAX_SEGMENTS,
  localparam int CP_DEPTH = MAX_SEGMENTS * CP_PER_SEG,
  localparam int CP_AW    = $clog2(CP_DEPTH),
  localparam int SEG_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cp_we,
  input  logic [CP_AW-1:0] cp_waddr,
  input  coord_t           cp_wdata,
  input  logic             start,
  input  logic [SEG_W-1:0] seg,
  input  logic [16:0]      t_loc,
  output logic             done,
  output point_t           pnt
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WGT  = 2'd1;
  localparam logic [1:0] PH_MAC  = 2'd2;

  coord_t cp_mem [CP_DEPTH];
  coord_t cp_rd_r;

  logic [1:0]          ph_r;
  logic [2:0]          ws_r;
  logic [3:0]          ic_r;
  logic [SEG_W-1:0]    seg_r;
  logic [16:0]         t_r, u_r;
  logic [32:0]         uu_r, tt_r;
  weight_t             w_r [4];
  logic signed [52:0]  prod_r;
  logic signed [49:0]  acc_r [3];
  logic                rd_v_r, mv_r, done_r;
  logic [1:0]          rd_i_r, rd_a_r, mi_r, ma_r;

  logic signed [34:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [52:0]  prod_nxt;
  logic                issue;
  logic [CP_AW-1:0]    rd_addr;
  logic signed [49:0]  rnd [3];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ph_r == PH_WGT) begin
      case (ws_r)
        3'd0: begin mul_a = $signed({18'd0, u_r}); mul_b = $signed({1'b0, u_r}); end
        3'd1: begin mul_a = $signed({18'd0, t_r}); mul_b = $signed({1'b0, t_r}); end
        3'd2: begin mul_a = $signed({2'd0, uu_r}); mul_b = $signed({1'b0, u_r}); end
        3'd3: begin
          mul_a = $signed({1'b0, ({1'b0, uu_r} + {uu_r, 1'b0})});
          mul_b = $signed({1'b0, t_r});
        end
        3'd4: begin
          mul_a = $signed({1'b0, ({1'b0, tt_r} + {tt_r, 1'b0})});
          mul_b = $signed({1'b0, u_r});
        end
        3'd5: begin mul_a = $signed({2'd0, tt_r}); mul_b = $signed({1'b0, t_r}); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (rd_v_r) begin
      mul_a = $signed({2'd0, w_r[rd_i_r]});
      mul_b = {{2{cp_rd_r[15]}}, cp_rd_r};
    end
  end

  assign prod_nxt = mul_a * mul_b;
  assign issue    = (ph_r == PH_MAC) && (ic_r < 4'(CP_PER_SEG));
  // word order: control point outer, axis inner
  assign rd_addr  = CP_AW'(32'(seg_r) * CP_PER_SEG + 32'(ic_r[1:0]) * NUM_AXES
                           + 32'(ic_r[3:2]));

  always_ff @(posedge clk) begin
    if (cp_we) cp_mem[cp_waddr] <= cp_wdata;
    cp_rd_r <= cp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      rd_v_r <= 1'b0;
      mv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      prod_r <= prod_nxt;
      rd_v_r <= issue;
      rd_i_r <= ic_r[1:0];
      rd_a_r <= ic_r[3:2];
      mv_r   <= rd_v_r;
      mi_r   <= rd_i_r;
      ma_r   <= rd_a_r;
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: if (start) begin
          seg_r <= seg;
          t_r   <= t_loc;
          u_r   <= T_ONE - t_loc;
          ws_r  <= 3'd0;
          ph_r  <= PH_WGT;
        end
        PH_WGT: begin
          ws_r <= ws_r + 3'd1;
          case (ws_r)
            3'd1: uu_r   <= prod_r[32:0];
            3'd2: tt_r   <= prod_r[32:0];
            3'd3: w_r[0] <= prod_r[48:16];
            3'd4: w_r[1] <= prod_r[48:16];
            3'd5: w_r[2] <= prod_r[48:16];
            3'd6: begin
              w_r[3] <= prod_r[48:16];
              ic_r   <= 4'd0;
              ph_r   <= PH_MAC;
            end
            default: ;
          endcase
        end
        PH_MAC: begin
          if (issue) ic_r <= ic_r + 4'd1;
          if (mv_r) begin
            acc_r[ma_r] <= ((mi_r == 2'd0) ? 50'sd0 : acc_r[ma_r]) + prod_r[49:0];
            if (ma_r == 2'd2 && mi_r == 2'd3) begin
              done_r <= 1'b1;
              ph_r   <= PH_IDLE;
            end
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  // round half up to q8.8
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) rnd[a] = acc_r[a] + 50'sh80000000;
  end

  assign done  = done_r;
  assign pnt.x = rnd[0][47:32];
  assign pnt.y = rnd[1][47:32];
  assign pnt.z = rnd[2][47:32];

endmodule

`default_nettype wire

// File: rtl/bpal_isqrt.sv
// ----------------------------------------------------------------------------
// bpal_isqrt
// floor square root of a 34-bit value, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bpal_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [33:0] rad,
  output logic        done,
  output logic [16:0] root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [33:0] rad_r;
  logic [20:0] rem_r;
  logic [16:0] root_r;

  logic [20:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_r[18:0], rad_r[33:32]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd16;
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[31:0], 2'b00};
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[15:0], ge};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: rtl/bezier_path_arc_length_eval.sv
// ----------------------------------------------------------------------------
// bezier_path_arc_length_eval
// piecewise cubic bezier path with a cumulative arc-length table: coordinate
// writes, table rebuild, point at path time and point at distance
// ----------------------------------------------------------------------------
// a coordinate write passes through the finish state to the result word; point
//   at time runs through the point evaluator (weight products, 12 mac passes
//   through one multiplier, 2 pipeline stages)
// point at distance: adds a binary search of the table, then restoring
//   division for the table time
// rebuild: each chord costs one point evaluation, three squares and 17
//   square-root steps
// one word at a time; reset clears control state, segment and table counts
//   only, point and table memories are undefined until written, no clear pass
`default_nettype none

module bezier_path_arc_length_eval
  import bpal_pkg::*;
#(
  parameter int MAX_SEGMENTS        = BPAL_MAX_SEGMENTS,
  parameter int ENTRIES_PER_SEGMENT = BPAL_ENTRIES_PER_SEGMENT,
  parameter int SAMPLES_PER_ENTRY   = BPAL_SAMPLES_PER_ENTRY
) (
  input  logic        clk,
  input  logic        rst_n,
  bpal_in_if.sink     in_if,
  bpal_out_if.source  out_if,
  bpal_cfg_if.sink    cfg_if
);

  localparam int ARC_DEPTH = MAX_SEGMENTS * ENTRIES_PER_SEGMENT;
  localparam int AI_W      = $clog2(ARC_DEPTH);
  localparam int TE_W      = $clog2(ARC_DEPTH + 1);
  localparam int DR_W      = TE_W + 1;
  localparam int CP_DEPTH  = MAX_SEGMENTS * CP_PER_SEG;
  localparam int CP_AW     = $clog2(CP_DEPTH);
  localparam int SEG_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  // sample times advance by a fixed quotient and remainder step
  localparam int DEN       = ENTRIES_PER_SEGMENT * SAMPLES_PER_ENTRY;
  localparam int QSTEP     = 65536 / DEN;
  localparam int RSTEP     = 65536 % DEN;
  localparam int R_W       = $clog2(2 * DEN);
  localparam int KC_W      = $clog2(SAMPLES_PER_ENTRY + 1);
  localparam int JC_W      = $clog2(ENTRIES_PER_SEGMENT);
  localparam logic [2:0] MAXS3 = (MAX_SEGMENTS > 7) ? 3'd7 : 3'(MAX_SEGMENTS);

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIN     = 4'd1;
  localparam logic [3:0] S_PT_GO   = 4'd2;
  localparam logic [3:0] S_PT_WAIT = 4'd3;
  localparam logic [3:0] S_RB_GO   = 4'd4;
  localparam logic [3:0] S_RB_WAIT = 4'd5;
  localparam logic [3:0] S_RB_SQ   = 4'd6;
  localparam logic [3:0] S_RB_SQS  = 4'd7;
  localparam logic [3:0] S_RB_SQRT = 4'd8;
  localparam logic [3:0] S_DS_LAST = 4'd9;
  localparam logic [3:0] S_DS_LCHK = 4'd10;
  localparam logic [3:0] S_DS_MID  = 4'd11;
  localparam logic [3:0] S_DS_CMP  = 4'd12;
  localparam logic [3:0] S_DS_DIV  = 4'd13;

  logic [3:0]      state_r;
  logic [2:0]      num_r;
  logic [TE_W-1:0] te_r;

  // result word
  logic            out_valid_r, out_status_r;
  point_t          out_p_r;
  logic            res_status_r;
  point_t          res_p_r;

  // query registers
  logic [16:0]     pt_time_r;
  logic [23:0]     dist_r;
  logic [AI_W-1:0] lo_r, hi_r, mid_r;
  logic [DR_W-1:0] drem_r;
  logic [15:0]     dq_r;
  logic [3:0]      dcnt_r;

  // rebuild registers
  logic [2:0]      rb_seg_r;
  logic [TE_W-1:0] tptr_r;
  logic [23:0]     total_r;
  logic [16:0]     q_r;
  logic [R_W-1:0]  r_r;
  logic [KC_W-1:0] kcnt_r;
  logic [JC_W-1:0] jcnt_r;
  logic            first_r;
  point_t          prev_r, cur_r;
  logic [33:0]     sq_r;
  logic [1:0]      ax_r;

  // arc-length table
  logic [23:0]     arc_mem [ARC_DEPTH];
  logic [23:0]     arc_rd_r;
  logic [AI_W-1:0] arc_raddr;
  logic            arc_we;

  logic            in_acc, bad_seg;
  logic [2:0]      eff;
  logic            cp_we;
  logic [CP_AW-1:0] cp_waddr;

  logic            ev_start, ev_done;
  logic [SEG_W-1:0] ev_seg;
  logic [16:0]     ev_t;
  point_t          ev_pnt;

  logic            sq_start, sq_done;
  logic [16:0]     sq_root;

  logic [19:0]     pt_prod;
  logic [2:0]      s_sel, effm1;
  logic [16:0]     loc_t;
  logic [AI_W:0]   lo_hi;
  logic [AI_W-1:0] mid;
  logic [AI_W-1:0] te_last;
  logic [DR_W-1:0] rem2;
  logic            div_ge;
  logic [R_W-1:0]  r_add;
  logic signed [15:0] c_cur, c_prev;
  logic signed [16:0] d;
  logic signed [33:0] dsq;
  logic [24:0]     sum25;
  logic [23:0]     total_sat;

  // segments above the supported count act as the maximum
  assign eff     = (num_r > MAXS3) ? MAXS3 : num_r;
  assign in_acc  = in_if.valid && in_if.ready;
  assign bad_seg = ({1'b0, in_if.segment} >= eff);

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;

  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.pos_x  = out_p_r.x;
  assign out_if.pos_y  = out_p_r.y;
  assign out_if.pos_z  = out_p_r.z;

  // control point write, taken straight from the command word
  assign cp_we    = in_acc && (in_if.operation == OP_WRITE) && !bad_seg
                    && (in_if.axis < 2'(NUM_AXES));
  assign cp_waddr = CP_AW'((32'(in_if.segment) * PTS_PER_SEG + 32'(in_if.point_index))
                           * NUM_AXES + 32'(in_if.axis));

  // path time to segment and local time
  assign pt_prod = 20'(pt_time_r) * 20'(eff);
  assign effm1   = eff - 3'd1;
  assign s_sel   = (pt_prod[19:16] > {1'b0, effm1}) ? effm1 : pt_prod[18:16];
  assign loc_t   = 17'(pt_prod - {1'b0, s_sel, 16'd0});

  assign ev_start = ((state_r == S_PT_GO) && (eff != 3'd0)) || (state_r == S_RB_GO);
  assign ev_seg   = (state_r == S_RB_GO) ? SEG_W'(rb_seg_r) : SEG_W'(s_sel);
  assign ev_t     = (state_r == S_RB_GO) ? q_r : loc_t;

  bpal_point #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_point (
    .clk      (clk),
    .rst_n    (rst_n),
    .cp_we    (cp_we),
    .cp_waddr (cp_waddr),
    .cp_wdata (in_if.coord_value),
    .start    (ev_start),
    .seg      (ev_seg),
    .t_loc    (ev_t),
    .done     (ev_done),
    .pnt      (ev_pnt)
  );

  // chord: squared difference of one axis per cycle
  always_comb begin
    case (ax_r)
      2'd0:    begin c_cur = cur_r.x; c_prev = prev_r.x; end
      2'd1:    begin c_cur = cur_r.y; c_prev = prev_r.y; end
      default: begin c_cur = cur_r.z; c_prev = prev_r.z; end
    endcase
  end

  assign d        = {c_cur[15], c_cur} - {c_prev[15], c_prev};
  assign dsq      = d * d;
  assign sq_start = (state_r == S_RB_SQS);

  bpal_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (sq_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  // running length saturates at the top of q16.8
  assign sum25     = {1'b0, total_r} + 25'(sq_root);
  assign total_sat = sum25[24] ? DIST_MAX : sum25[23:0];

  // sample time step with remainder carry
  assign r_add = r_r + R_W'(RSTEP);

  // binary search and table-time division
  assign lo_hi   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = lo_hi[AI_W:1];
  assign te_last = AI_W'(te_r - 1'b1);
  assign rem2    = {drem_r[TE_W-1:0], 1'b0};
  assign div_ge  = (rem2 >= {1'b0, te_r});

  assign arc_we = (state_r == S_RB_SQRT) && sq_done
                  && (kcnt_r == KC_W'(SAMPLES_PER_ENTRY - 1));

  always_comb begin
    unique case (state_r)
      S_DS_LAST: arc_raddr = te_last;
      S_DS_MID:  arc_raddr = mid;
      default:   arc_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (arc_we) arc_mem[tptr_r[AI_W-1:0]] <= total_sat;
    arc_rd_r <= arc_mem[arc_raddr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_r       <= '0;
      te_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) num_r <= cfg_if.data;
      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: if (in_acc) begin
          res_status_r <= STAT_OK;
          res_p_r      <= '0;
          unique case (in_if.operation)
            OP_WRITE: begin
              if (bad_seg) res_status_r <= STAT_BAD_SEG;
              state_r <= S_FIN;
            end
            OP_REBUILD: begin
              if (eff == 3'd0) begin
                te_r    <= '0;
                state_r <= S_FIN;
              end else begin
                rb_seg_r <= '0;
                tptr_r   <= '0;
                total_r  <= '0;
                q_r      <= '0;
                r_r      <= R_W'(DEN / 2);
                kcnt_r   <= '0;
                jcnt_r   <= '0;
                first_r  <= 1'b1;
                state_r  <= S_RB_GO;
              end
            end
            OP_AT_TIME: begin
              pt_time_r <= (in_if.time_value > T_ONE) ? T_ONE : in_if.time_value;
              state_r   <= S_PT_GO;
            end
            OP_AT_DIST: begin
              dist_r <= in_if.distance_value;
              if (te_r == '0 || in_if.distance_value == 24'd0) begin
                pt_time_r <= '0;
                state_r   <= S_PT_GO;
              end else begin
                state_r <= S_DS_LAST;
              end
            end
            default: state_r <= S_FIN;
          endcase
        end

        // no segments in use: origin
        S_PT_GO: state_r <= (eff == 3'd0) ? S_FIN : S_PT_WAIT;

        S_PT_WAIT: if (ev_done) begin
          res_p_r <= ev_pnt;
          state_r <= S_FIN;
        end

        S_RB_GO: state_r <= S_RB_WAIT;

        S_RB_WAIT: if (ev_done) begin
          if (r_add >= R_W'(DEN)) begin
            r_r <= r_add - R_W'(DEN);
            q_r <= q_r + 17'(QSTEP + 1);
          end else begin
            r_r <= r_add;
            q_r <= q_r + 17'(QSTEP);
          end
          if (first_r) begin
            // first sample of a segment only opens the chord chain
            prev_r  <= ev_pnt;
            first_r <= 1'b0;
            state_r <= S_RB_GO;
          end else begin
            cur_r   <= ev_pnt;
            sq_r    <= '0;
            ax_r    <= '0;
            state_r <= S_RB_SQ;
          end
        end

        S_RB_SQ: begin
          sq_r <= sq_r + $unsigned(dsq);
          ax_r <= ax_r + 2'd1;
          if (ax_r == 2'd2) state_r <= S_RB_SQS;
        end

        S_RB_SQS: state_r <= S_RB_SQRT;

        S_RB_SQRT: if (sq_done) begin
          total_r <= total_sat;
          prev_r  <= cur_r;
          if (kcnt_r == KC_W'(SAMPLES_PER_ENTRY - 1)) begin
            // entry complete, table word written this cycle
            tptr_r <= tptr_r + 1'b1;
            kcnt_r <= '0;
            if (jcnt_r == JC_W'(ENTRIES_PER_SEGMENT - 1)) begin
              jcnt_r <= '0;
              if (rb_seg_r + 3'd1 == eff) begin
                te_r    <= tptr_r + 1'b1;
                state_r <= S_FIN;
              end else begin
                rb_seg_r <= rb_seg_r + 3'd1;
                q_r      <= '0;
                r_r      <= R_W'(DEN / 2);
                first_r  <= 1'b1;
                state_r  <= S_RB_GO;
              end
            end else begin
              jcnt_r  <= jcnt_r + 1'b1;
              state_r <= S_RB_GO;
            end
          end else begin
            kcnt_r  <= kcnt_r + 1'b1;
            state_r <= S_RB_GO;
          end
        end

        S_DS_LAST: state_r <= S_DS_LCHK;

        // at or past the table end: path end
        S_DS_LCHK: begin
          if (dist_r >= arc_rd_r) begin
            pt_time_r <= T_ONE;
            state_r   <= S_PT_GO;
          end else begin
            lo_r    <= '0;
            hi_r    <= te_last;
            state_r <= S_DS_MID;
          end
        end

        S_DS_MID: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid;
            state_r <= S_DS_CMP;
          end else begin
            drem_r  <= DR_W'(lo_r);
            dq_r    <= '0;
            dcnt_r  <= '0;
            state_r <= S_DS_DIV;
          end
        end

        S_DS_CMP: begin
          if (arc_rd_r == dist_r) begin
            // exact hit ends the search
            drem_r  <= DR_W'(mid_r);
            dq_r    <= '0;
            dcnt_r  <= '0;
            state_r <= S_DS_DIV;
          end else if (arc_rd_r < dist_r) begin
            lo_r    <= AI_W'(mid_r + 1'b1);
            state_r <= S_DS_MID;
          end else begin
            hi_r    <= mid_r;
            state_r <= S_DS_MID;
          end
        end

        // index * 65536 / entries, one quotient bit per cycle
        S_DS_DIV: begin
          drem_r <= div_ge ? (rem2 - {1'b0, te_r}) : rem2;
          dq_r   <= {dq_r[14:0], div_ge};
          dcnt_r <= dcnt_r + 4'd1;
          if (dcnt_r == 4'd15) begin
            pt_time_r <= {1'b0, dq_r[14:0], div_ge};
            state_r   <= S_PT_GO;
          end
        end

        // result waits here only while the previous word is still held
        S_FIN: if (!out_valid_r || out_if.ready) begin
          out_valid_r  <= 1'b1;
          out_status_r <= res_status_r;
          out_p_r      <= res_p_r;
          state_r      <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // table count never runs past the table
  a_te_range: assert property (@(posedge clk) disable iff (!rst_n)
    te_r <= TE_W'(ARC_DEPTH))
    else $error("table count beyond table depth");

  // table writes stay inside the table
  a_arc_wr: assert property (@(posedge clk) disable iff (!rst_n)
    arc_we |-> (tptr_r < TE_W'(ARC_DEPTH)))
    else $error("arc table write out of range");

  // evaluator finishes only while the sequencer waits for it
  a_ev_done: assert property (@(posedge clk) disable iff (!rst_n)
    ev_done |-> (state_r == S_PT_WAIT || state_r == S_RB_WAIT))
    else $error("point evaluator done outside a wait state");

  // square root finishes only while a chord is pending
  a_sq_done: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_RB_SQRT))
    else $error("square root done outside chord wait");

  // point evaluator starts never come back to back
  a_ev_start: assert property (@(posedge clk) disable iff (!rst_n)
    ev_start |=> !ev_start)
    else $error("back-to-back evaluator starts");

endmodule

`default_nettype wire
